/* sv/neighbor_contrast_weights_defines.svh */
// Assertion macros for the neighbor contrast weight block.
// Used by the top level; no other dependencies.
`ifndef NEIGHBOR_CONTRAST_WEIGHTS_DEFINES_SVH
`define NEIGHBOR_CONTRAST_WEIGHTS_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define NCW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ncw assertion failed");
// next-cycle implication
`define NCW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ncw assertion failed");
`else
`define NCW_ASSERT_IMP(lbl, ante, cons)
`define NCW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/ncw_pkg.sv */
// Shared types, register codes and helpers for the neighbor contrast weights block.
// No dependencies.
package ncw_pkg;

	// input word: one RGB pixel
	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} pixel_t;

	// output word: one result per pixel
	typedef struct packed {
		logic [15:0] weight_left;
		logic [15:0] weight_upleft;
		logic [15:0] weight_up;
		logic [15:0] weight_upright;
		logic        has_left;
		logic        has_upleft;
		logic        has_up;
		logic        has_upright;
		logic [47:0] contrast_sum;
		logic        frame_end;
	} result_t;

	// classified pixel handed from front to back
	typedef struct packed {
		pixel_t     pix;
		logic [3:0] has;
		logic       first;
		logic       frame_end;
	} item_t;

	// settings the back end needs
	typedef struct packed {
		logic        mode;
		logic [31:0] beta;
		logic [15:0] gamma;
	} wcfg_t;

	// neighbor slots
	localparam logic [1:0] NB_LEFT    = 2'd0;
	localparam logic [1:0] NB_UPLEFT  = 2'd1;
	localparam logic [1:0] NB_UP      = 2'd2;
	localparam logic [1:0] NB_UPRIGHT = 2'd3;

	// register indexes
	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_WIDTH  = 3'd1;
	localparam logic [2:0] REG_HEIGHT = 3'd2;
	localparam logic [2:0] REG_BETA   = 3'd3;
	localparam logic [2:0] REG_GAMMA  = 3'd4;

	// reset values
	localparam logic [11:0] WIDTH_RST  = 12'd640;
	localparam logic [11:0] HEIGHT_RST = 12'd480;
	localparam logic [15:0] GAMMA_RST  = 16'd12800;

	localparam int SUM_W = 48;

	// exact squared color distance, at most 195075
	function automatic logic [17:0] dist2(input pixel_t a, input pixel_t b);
		logic [7:0] dr, dg, db;
		logic [15:0] sr, sg, sb;
		dr = (a.pixel_red > b.pixel_red) ? a.pixel_red - b.pixel_red
			: b.pixel_red - a.pixel_red;
		dg = (a.pixel_green > b.pixel_green) ? a.pixel_green - b.pixel_green
			: b.pixel_green - a.pixel_green;
		db = (a.pixel_blue > b.pixel_blue) ? a.pixel_blue - b.pixel_blue
			: b.pixel_blue - a.pixel_blue;
		sr = dr * dr;
		sg = dg * dg;
		sb = db * db;
		return 18'(sr) + 18'(sg) + 18'(sb);
	endfunction

endpackage

/* sv/neighbor_contrast_weights.sv */
// Top level of the neighbor contrast weight block: register port, front, queue, back.
// Depends on ncw_pkg, ncw_front, ncw_queue, ncw_back and the defines header.
//
// Takes RGB pixels in raster order and gives one word per pixel: weights and
// presence flags for the left, upper-left, up and upper-right neighbors, the
// frame's running squared-distance sum and an end-of-frame flag. Mode 0 sums
// distances (cleared at the first pixel of a frame); mode 1 gives
// gamma*exp(-beta*d2) per neighbor. The back end works on one pixel at a
// time: it pops and reads the line store, takes each neighbor in turn through
// the one shared distance, beta multiply, exp table and gamma multiply unit,
// and retires. The front end and a two-word queue take pixels ahead of that.
// Registers sit at byte addresses 0 mode, 4 width, 8 height, 12 beta,
// 16 gamma; write only while idle.
`include "neighbor_contrast_weights_defines.svh"
module neighbor_contrast_weights #(
	parameter int MAX_WIDTH       = 2048,
	parameter int MAX_HEIGHT      = 2048,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  ncw_pkg::pixel_t   pixel,
	output logic              result_valid,
	input  logic              result_stall,
	output ncw_pkg::result_t  result
);
	import ncw_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = CW + $bits(item_t);

	logic        mode_q;
	logic [11:0] width_q, height_q;
	logic [31:0] beta_q;
	logic [15:0] gamma_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	logic          push, pop, q_full, q_empty;
	item_t         push_item, q_item;
	logic [CW-1:0] push_col, q_col;
	wcfg_t         wcfg;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			beta_q   <= '0;
			gamma_q  <= GAMMA_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODE:   mode_q   <= pwdata[0];
				REG_WIDTH:  width_q  <= pwdata[11:0];
				REG_HEIGHT: height_q <= pwdata[11:0];
				REG_BETA:   beta_q   <= pwdata;
				REG_GAMMA:  gamma_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE:   prdata = {31'd0, mode_q};
			REG_WIDTH:  prdata = {20'd0, width_q};
			REG_HEIGHT: prdata = {20'd0, height_q};
			REG_BETA:   prdata = beta_q;
			REG_GAMMA:  prdata = {16'd0, gamma_q};
			default:    prdata = '0;
		endcase
	end

	assign wcfg.mode  = mode_q;
	assign wcfg.beta  = beta_q;
	assign wcfg.gamma = gamma_q;

	ncw_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.frame_width  (width_q),
		.frame_height (height_q),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item),
		.push_col     (push_col)
	);

	ncw_queue #(
		.W     (QW),
		.DEPTH (2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({push_col, push_item}),
		.pop    (pop),
		.dout   ({q_col, q_item}),
		.full   (q_full),
		.empty  (q_empty)
	);

	ncw_back #(
		.MAX_WIDTH       (MAX_WIDTH),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (wcfg),
		.q_empty      (q_empty),
		.q_item       (q_item),
		.q_col        (q_col),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// an accepted pixel is waiting in the queue next cycle
	`NCW_ASSERT_NEXT(a_pixel_queued, pixel_valid && !pixel_stall, !q_empty)
	// absent neighbors carry no weight
	`NCW_ASSERT_IMP(a_left_absent, result_valid && !result.has_left, result.weight_left == 16'd0)
	`NCW_ASSERT_IMP(a_upright_absent, result_valid && !result.has_upright, result.weight_upright == 16'd0)
	// an upper-left neighbor implies left and up neighbors
	`NCW_ASSERT_IMP(a_upleft_implies, result_valid && result.has_upleft, result.has_left && result.has_up)

endmodule

/* sv/ncw_front.sv */
// Front end: accepts pixels, tracks column and row, flags existing neighbors.
// Depends on ncw_pkg.
module ncw_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  ncw_pkg::pixel_t              pixel,
	input  logic [11:0]                  frame_width,
	input  logic [11:0]                  frame_height,
	input  logic                         q_full,
	output logic                         push,
	output ncw_pkg::item_t               push_item,
	output logic [$clog2(MAX_WIDTH)-1:0] push_col
);
	import ncw_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int EW = (WW > 12) ? WW : 12;
	localparam int EH = (HW > 12) ? HW : 12;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [EW-1:0] w_e, col_next;
	logic [EH-1:0] h_e, row_next;
	logic          last_col, last_row;

	// clamp frame size to 1..max
	always_comb begin
		if (frame_width == 12'd0) w_e = EW'(1);
		else if (EW'(frame_width) > EW'(MAX_WIDTH)) w_e = EW'(MAX_WIDTH);
		else w_e = EW'(frame_width);
		if (frame_height == 12'd0) h_e = EH'(1);
		else if (EH'(frame_height) > EH'(MAX_HEIGHT)) h_e = EH'(MAX_HEIGHT);
		else h_e = EH'(frame_height);
	end

	assign col_next = EW'(col_q) + EW'(1);
	assign row_next = EH'(row_q) + EH'(1);
	assign last_col = (col_next >= w_e);
	assign last_row = (row_next >= h_e);

	assign pixel_stall = q_full;
	assign push        = pixel_valid && !q_full;

	// classify the pixel
	always_comb begin
		push_item.pix              = pixel;
		push_item.has[NB_LEFT]     = (col_q != '0);
		push_item.has[NB_UPLEFT]   = (col_q != '0) && (row_q != '0);
		push_item.has[NB_UP]       = (row_q != '0);
		push_item.has[NB_UPRIGHT]  = (row_q != '0) && !last_col;
		push_item.first            = (col_q == '0) && (row_q == '0);
		push_item.frame_end        = last_col && last_row;
		push_col                   = col_q;
	end

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_next[RW-1:0];
			end else begin
				col_q <= col_next[CW-1:0];
			end
		end
	end

endmodule

/* sv/ncw_queue.sv */
// Short FIFO between front and back ends.
// No dependencies.
module ncw_queue #(
	parameter int W     = 42,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;

	assign full  = (cnt_q == NW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + NW'(1);
			else if (pop && !push) cnt_q <= cnt_q - NW'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule

/* sv/ncw_back.sv */
// Back end: line store, distances, exp table lookup, weights, running sum.
// Depends on ncw_pkg.
module ncw_back #(
	parameter int MAX_WIDTH       = 2048,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ncw_pkg::wcfg_t               cfg,
	input  logic                         q_empty,
	input  ncw_pkg::item_t               q_item,
	input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
	output logic                         pop,
	output logic                         result_valid,
	input  logic                         result_stall,
	output ncw_pkg::result_t             result
);
	import ncw_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int KW = $clog2(EXP_TABLE_DEPTH);
	localparam int PW = 28 + $clog2(EXP_TABLE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIST = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ROM  = 3'd3;
	localparam logic [2:0] ST_GAIN = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	typedef logic [32:0] rom_t [EXP_TABLE_DEPTH];

	// exp(-k*16/depth) in Q1.32, built by the integer Taylor recipe
	function automatic rom_t build_rom();
		rom_t        t;
		logic [63:0] s, r, term;
		s    = (64'd1 << 36) / 64'(EXP_TABLE_DEPTH);
		r    = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int n = 1; n < 64; n++) begin
			term = ((term * s) >> 32) / 64'(n);
			if (term == 64'd0) break;
			if (n % 2 == 1) r = r - term;
			else r = r + term;
		end
		t[0] = 33'h1_0000_0000;
		for (int k = 1; k < EXP_TABLE_DEPTH; k++)
			t[k] = 33'(({31'd0, t[k-1]} * r) >> 32);
		return t;
	endfunction

	localparam rom_t EXP_ROM = build_rom();

	logic [2:0]       state_q;
	logic [1:0]       nb_q;
	item_t            cur_q;
	logic [CW-1:0]    col_q;
	logic [23:0]      up_q, upright_q;
	logic [23:0]      upleft_q, left_q;
	logic [17:0]      d2_q;
	logic [49:0]      x_q;
	logic [32:0]      rom_q;
	logic             big_q;
	logic [15:0]      wts_q [4];
	logic [SUM_W-1:0] total_q;
	logic             res_valid_q;
	result_t          res_q;
	logic [23:0]      row_mem [MAX_WIDTH];

	logic [23:0]      nb_pix;
	logic [PW-1:0]    kprod;
	logic [KW-1:0]    k;
	logic [48:0]      gprod;
	logic [SUM_W:0]   sum_ext;
	logic             load;

	assign pop          = (state_q == ST_IDLE) && !q_empty;
	assign load         = (state_q == ST_OUT) && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// neighbor under work
	always_comb begin
		case (nb_q)
			NB_LEFT:   nb_pix = left_q;
			NB_UPLEFT: nb_pix = upleft_q;
			NB_UP:     nb_pix = up_q;
			default:   nb_pix = upright_q;
		endcase
	end

	assign kprod   = PW'(x_q[27:0]) * PW'(EXP_TABLE_DEPTH);
	assign k       = kprod[28 +: KW];
	assign gprod   = 49'(cfg.gamma) * 49'(rom_q);
	assign sum_ext = {1'b0, total_q} + (SUM_W + 1)'(d2_q);

	// sequencer, window, running sum, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nb_q        <= NB_LEFT;
			total_q     <= '0;
			left_q      <= '0;
			upleft_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// output word: set on retire, cleared once taken
			if (load) res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						nb_q    <= NB_LEFT;
						state_q <= ST_DIST;
						if (!cfg.mode && q_item.first) total_q <= '0;
					end
				end
				ST_DIST: state_q <= ST_MUL;
				ST_MUL: begin
					if (!cfg.mode && cur_q.has[nb_q])
						total_q <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
					state_q <= ST_ROM;
				end
				ST_ROM: state_q <= ST_GAIN;
				ST_GAIN: begin
					nb_q    <= nb_q + 2'd1;
					state_q <= (nb_q == NB_UPRIGHT) ? ST_OUT : ST_DIST;
				end
				ST_OUT: begin
					if (load) begin
						left_q   <= cur_q.pix;
						upleft_q <= up_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_item;
			col_q <= q_col;
		end
		if (state_q == ST_DIST)
			d2_q <= cur_q.has[nb_q] ? dist2(cur_q.pix, nb_pix) : 18'd0;
		if (state_q == ST_MUL)
			x_q <= 50'(cfg.beta) * 50'(d2_q);
		if (state_q == ST_ROM)
			big_q <= (x_q[49:28] != '0);
		if (state_q == ST_GAIN)
			wts_q[nb_q] <= (cfg.mode && cur_q.has[nb_q] && !big_q) ? gprod[47:32] : 16'd0;
		if (load) begin
			res_q.weight_left    <= wts_q[NB_LEFT];
			res_q.weight_upleft  <= wts_q[NB_UPLEFT];
			res_q.weight_up      <= wts_q[NB_UP];
			res_q.weight_upright <= wts_q[NB_UPRIGHT];
			res_q.has_left       <= cur_q.has[NB_LEFT];
			res_q.has_upleft     <= cur_q.has[NB_UPLEFT];
			res_q.has_up         <= cur_q.has[NB_UP];
			res_q.has_upright    <= cur_q.has[NB_UPRIGHT];
			res_q.contrast_sum   <= total_q;
			res_q.frame_end      <= cur_q.frame_end;
		end
	end

	// exp table, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_ROM) rom_q <= EXP_ROM[k];
	end

	// previous-row line store: two reads at pop, one write at retire
	always_ff @(posedge clk) begin
		if (pop) begin
			up_q      <= row_mem[q_col];
			upright_q <= row_mem[q_col + CW'(1)];
		end
		if (load) row_mem[col_q] <= cur_q.pix;
	end

endmodule
